### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the I2C transfer sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked on every rising edge outside reset.
`define I2CMS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Same-cycle implication checked on every rising edge outside reset.
`define I2CMS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("implication failed");

// Next-cycle implication checked on every rising edge outside reset.
`define I2CMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

### rtl/core/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types, codes and widths of the I2C master transfer sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

  // Default buffer depth in bytes
  localparam int unsigned BUFFER_BYTES_DEF = 32;

  // Field widths
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned ADDR_W   = 7;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned INDEX_W  = 5;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 4;
  localparam int unsigned RC_W     = 3;
  localparam int unsigned ACT_W    = 4;
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned AVAIL_W  = 6;

  // Item operation
  typedef enum logic [MODE_W-1:0] {
    MODE_STAGE    = 3'd0,
    MODE_REQ_WR   = 3'd1,
    MODE_REQ_RD   = 3'd2,
    MODE_EVENT    = 3'd3,
    MODE_READ_BUF = 3'd4
  } mode_e;

  // Bus status reported by the bus engine
  typedef enum logic [STATUS_W-1:0] {
    ST_START      = 4'd0,
    ST_REP_START  = 4'd1,
    ST_MT_SLA_ACK = 4'd2,
    ST_MT_DAT_ACK = 4'd3,
    ST_MT_SLA_NAK = 4'd4,
    ST_MT_DAT_NAK = 4'd5,
    ST_ARB_LOST   = 4'd6,
    ST_MR_DAT_ACK = 4'd7,
    ST_MR_SLA_ACK = 4'd8,
    ST_MR_DAT_NAK = 4'd9,
    ST_MR_SLA_NAK = 4'd10,
    ST_NO_INFO    = 4'd11,
    ST_BUS_ERROR  = 4'd12
  } status_e;

  // Bus action handed back to the bus engine
  typedef enum logic [ACT_W-1:0] {
    ACT_NONE          = 4'd0,
    ACT_START         = 4'd1,
    ACT_SEND          = 4'd2,
    ACT_ACK           = 4'd3,
    ACT_NACK          = 4'd4,
    ACT_STOP          = 4'd5,
    ACT_STOP_START    = 4'd6,
    ACT_RELEASE       = 4'd7,
    ACT_RELEASE_START = 4'd8
  } action_e;

  // Return codes
  typedef enum logic [RC_W-1:0] {
    RC_OK        = 3'd0,
    RC_TOO_LONG  = 3'd1,
    RC_ADDR_NACK = 3'd2,
    RC_DATA_NACK = 3'd3,
    RC_OTHER     = 3'd4
  } rc_e;

  // Driver phase
  typedef enum logic [PHASE_W-1:0] {
    PH_READY = 3'd0,
    PH_TX    = 3'd1,
    PH_RX    = 3'd2,
    PH_WPEND = 3'd3,
    PH_RPEND = 3'd4
  } phase_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic fetch;
    logic exec;
    logic copy_step;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic copy_start;
    logic copy_last;
  } stat_t;

endpackage

`default_nettype wire

### rtl/core/i2cms_ctrl.sv
// ----------------------------------------------------------------------------
// i2cms_ctrl
// Sequencing state machine: accepts a beat, steps the datapath through
// fetch, execute and staged-data copy, and owns the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module i2cms_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire i2cms_pkg::stat_t stat_i,
  output i2cms_pkg::cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_EXEC,
    S_COPY,
    S_DRAIN,
    S_RESULT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Commands decoded from the current state
  always_comb begin
    cmd_o           = '0;
    cmd_o.load_in   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.fetch     = (state_q == S_FETCH);
    cmd_o.exec      = (state_q == S_EXEC);
    cmd_o.copy_step = (state_q == S_COPY);
    cmd_o.load_out  = (state_q == S_RESULT) && out_free;
  end

  // State and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_FETCH;
        end
        S_FETCH: begin
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          state_q <= stat_i.copy_start ? S_COPY : S_RESULT;
        end
        S_COPY: begin
          if (stat_i.copy_last) state_q <= S_DRAIN;
        end
        S_DRAIN: begin
          state_q <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `I2CMS_ASSERT_NEXT(a_one_item_in_flight, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `I2CMS_ASSERT_IMPL(a_copy_after_exec, clk_i, rst_ni, state_q == S_COPY, $past(state_q) == S_EXEC || $past(state_q) == S_COPY)

endmodule

`default_nettype wire

### rtl/core/i2cms_datapath.sv
// ----------------------------------------------------------------------------
// i2cms_datapath
// Driver state, staging and transfer buffers, bus event decode and the
// result registers of the I2C transfer sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module i2cms_datapath #(
  parameter int unsigned BUFFER_BYTES = i2cms_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire i2cms_pkg::cmd_t                  cmd_i,
  output i2cms_pkg::stat_t                      stat_o,
  input  wire logic [i2cms_pkg::MODE_W-1:0]     mode_i,
  input  wire logic [i2cms_pkg::ADDR_W-1:0]     target_address_i,
  input  wire logic [i2cms_pkg::COUNT_W-1:0]    byte_count_i,
  input  wire logic [i2cms_pkg::INDEX_W-1:0]    byte_index_i,
  input  wire logic [i2cms_pkg::BYTE_W-1:0]     data_byte_i,
  input  wire logic [i2cms_pkg::STATUS_W-1:0]   bus_status_i,
  output logic      [i2cms_pkg::RC_W-1:0]       return_code_o,
  output logic      [i2cms_pkg::ACT_W-1:0]      bus_action_o,
  output logic      [i2cms_pkg::BYTE_W-1:0]     bus_byte_o,
  output logic      [i2cms_pkg::PHASE_W-1:0]    driver_state_o,
  output logic      [i2cms_pkg::AVAIL_W-1:0]    bytes_available_o,
  output logic      [i2cms_pkg::BYTE_W-1:0]     buffer_byte_o
);

  localparam int unsigned IDX_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam int unsigned CNT_W = $clog2(BUFFER_BYTES + 1);
  localparam logic [i2cms_pkg::COUNT_W-1:0] BUF_LIM = i2cms_pkg::COUNT_W'(BUFFER_BYTES);

  // Captured item
  logic [i2cms_pkg::MODE_W-1:0]   mode_q;
  logic [i2cms_pkg::ADDR_W-1:0]   addr_q;
  logic [i2cms_pkg::COUNT_W-1:0]  count_q;
  logic [i2cms_pkg::INDEX_W-1:0]  index_q;
  logic [i2cms_pkg::BYTE_W-1:0]   data_q;
  logic [i2cms_pkg::STATUS_W-1:0] status_q;

  // Driver state
  i2cms_pkg::phase_e            phase_q, phase_d;
  i2cms_pkg::rc_e               err_q, err_d;
  logic [CNT_W-1:0]             pos_q, pos_d;
  logic [CNT_W-1:0]             lim_q, lim_d;
  logic [i2cms_pkg::BYTE_W-1:0] awd_q, awd_d;
  logic [i2cms_pkg::ADDR_W-1:0] pw_addr_q, pw_addr_d;
  logic [CNT_W-1:0]             pw_cnt_q, pw_cnt_d;
  logic [i2cms_pkg::ADDR_W-1:0] pr_addr_q, pr_addr_d;
  logic [CNT_W-1:0]             pr_cnt_q, pr_cnt_d;

  // Buffers
  logic [i2cms_pkg::BYTE_W-1:0] stg_mem  [BUFFER_BYTES];
  logic [i2cms_pkg::BYTE_W-1:0] xfer_mem [BUFFER_BYTES];
  logic [i2cms_pkg::BYTE_W-1:0] xfer_rd_q;
  logic [i2cms_pkg::BYTE_W-1:0] stg_rd_q;
  logic [IDX_W-1:0]             rd_addr;

  // Staged-data copy
  logic [IDX_W-1:0] copy_idx_q;
  logic [CNT_W-1:0] copy_n_q;
  logic             cwr_q;
  logic [IDX_W-1:0] cwr_addr_q;

  // Result of the executed beat
  i2cms_pkg::rc_e                rc_d, res_rc_q;
  i2cms_pkg::action_e            act_d, res_act_q;
  logic [i2cms_pkg::BYTE_W-1:0]  byte_d, res_byte_q;
  logic [i2cms_pkg::AVAIL_W-1:0] avail_d, res_avail_q;
  logic [i2cms_pkg::BYTE_W-1:0]  bufb_d, res_bufb_q;
  i2cms_pkg::phase_e             res_phase_q;

  // Output register
  logic [i2cms_pkg::RC_W-1:0]    rc_oq;
  logic [i2cms_pkg::ACT_W-1:0]   act_oq;
  logic [i2cms_pkg::BYTE_W-1:0]  byte_oq;
  logic [i2cms_pkg::PHASE_W-1:0] phase_oq;
  logic [i2cms_pkg::AVAIL_W-1:0] avail_oq;
  logic [i2cms_pkg::BYTE_W-1:0]  bufb_oq;

  // Execute-stage control
  logic               take_we;
  logic               stg_we;
  logic               launch_w;
  logic               launch_r;
  logic               fin;
  i2cms_pkg::action_e fin_plain;
  i2cms_pkg::action_e fin_start;
  logic               idx_ok;
  logic               pos_ok;
  logic               is_wr;
  logic [i2cms_pkg::COUNT_W-1:0] pos8;

  assign idx_ok = i2cms_pkg::COUNT_W'(index_q) < BUF_LIM;
  assign pos8   = i2cms_pkg::COUNT_W'(pos_q);
  assign pos_ok = pos8 < BUF_LIM;
  assign is_wr  = (i2cms_pkg::mode_e'(mode_q) == i2cms_pkg::MODE_REQ_WR);

  // Transfer store read address: buffer read-out or next byte to send
  assign rd_addr = (i2cms_pkg::mode_e'(mode_q) == i2cms_pkg::MODE_READ_BUF)
                   ? IDX_W'(index_q) : IDX_W'(pos_q);

  // Beat execution
  always_comb begin
    phase_d   = phase_q;
    err_d     = err_q;
    pos_d     = pos_q;
    lim_d     = lim_q;
    awd_d     = awd_q;
    pw_addr_d = pw_addr_q;
    pw_cnt_d  = pw_cnt_q;
    pr_addr_d = pr_addr_q;
    pr_cnt_d  = pr_cnt_q;
    rc_d      = i2cms_pkg::RC_OK;
    act_d     = i2cms_pkg::ACT_NONE;
    byte_d    = '0;
    avail_d   = '0;
    bufb_d    = '0;
    take_we   = 1'b0;
    stg_we    = 1'b0;
    launch_w  = 1'b0;
    launch_r  = 1'b0;
    fin       = 1'b0;
    fin_plain = i2cms_pkg::ACT_STOP;
    fin_start = i2cms_pkg::ACT_STOP_START;

    case (i2cms_pkg::mode_e'(mode_q))
      i2cms_pkg::MODE_STAGE: begin
        stg_we = idx_ok;
      end
      i2cms_pkg::MODE_REQ_WR, i2cms_pkg::MODE_REQ_RD: begin
        if (count_q > BUF_LIM) begin
          rc_d = i2cms_pkg::RC_TOO_LONG;
        end else begin
          if (is_wr) begin
            pw_addr_d = addr_q;
            pw_cnt_d  = CNT_W'(count_q);
          end else begin
            pr_addr_d = addr_q;
            pr_cnt_d  = CNT_W'(count_q);
          end
          if (phase_q == i2cms_pkg::PH_READY) begin
            launch_w = is_wr;
            launch_r = !is_wr;
            act_d    = i2cms_pkg::ACT_START;
          end else begin
            phase_d = is_wr ? i2cms_pkg::PH_WPEND : i2cms_pkg::PH_RPEND;
            rc_d    = err_q;
          end
        end
      end
      i2cms_pkg::MODE_EVENT: begin
        case (i2cms_pkg::status_e'(status_q))
          i2cms_pkg::ST_START, i2cms_pkg::ST_REP_START: begin
            act_d  = i2cms_pkg::ACT_SEND;
            byte_d = awd_q;
          end
          i2cms_pkg::ST_MT_SLA_ACK, i2cms_pkg::ST_MT_DAT_ACK: begin
            if ((pos_q < lim_q) && pos_ok) begin
              act_d  = i2cms_pkg::ACT_SEND;
              byte_d = xfer_rd_q;
              pos_d  = pos_q + CNT_W'(1);
            end else begin
              fin = 1'b1;
            end
          end
          i2cms_pkg::ST_MT_SLA_NAK: begin
            err_d = i2cms_pkg::RC_ADDR_NACK;
            fin   = 1'b1;
          end
          i2cms_pkg::ST_MT_DAT_NAK: begin
            err_d = i2cms_pkg::RC_DATA_NACK;
            fin   = 1'b1;
          end
          i2cms_pkg::ST_ARB_LOST: begin
            err_d     = i2cms_pkg::RC_OTHER;
            fin       = 1'b1;
            fin_plain = i2cms_pkg::ACT_RELEASE;
            fin_start = i2cms_pkg::ACT_RELEASE_START;
          end
          i2cms_pkg::ST_MR_DAT_ACK, i2cms_pkg::ST_MR_SLA_ACK: begin
            if ((i2cms_pkg::status_e'(status_q) == i2cms_pkg::ST_MR_DAT_ACK) && pos_ok) begin
              take_we = 1'b1;
              pos_d   = pos_q + CNT_W'(1);
            end
            act_d = (pos_d < lim_q) ? i2cms_pkg::ACT_ACK : i2cms_pkg::ACT_NACK;
          end
          i2cms_pkg::ST_MR_DAT_NAK, i2cms_pkg::ST_MR_SLA_NAK: begin
            if ((i2cms_pkg::status_e'(status_q) == i2cms_pkg::ST_MR_DAT_NAK) && pos_ok) begin
              take_we = 1'b1;
              pos_d   = pos_q + CNT_W'(1);
            end
            fin = 1'b1;
          end
          i2cms_pkg::ST_BUS_ERROR: begin
            err_d = i2cms_pkg::RC_OTHER;
            fin   = 1'b1;
          end
          default: begin
            act_d = i2cms_pkg::ACT_NONE;
          end
        endcase
      end
      i2cms_pkg::MODE_READ_BUF: begin
        avail_d = (pos8 < count_q) ? i2cms_pkg::AVAIL_W'(pos8)
                                   : i2cms_pkg::AVAIL_W'(count_q);
        bufb_d  = idx_ok ? xfer_rd_q : '0;
      end
      default: begin
        rc_d = i2cms_pkg::RC_OK;
      end
    endcase

    // End of bus ownership: back to ready or launch the pending request
    if (fin) begin
      if (phase_q == i2cms_pkg::PH_WPEND) begin
        launch_w = 1'b1;
        act_d    = fin_start;
      end else if (phase_q == i2cms_pkg::PH_RPEND) begin
        launch_r = 1'b1;
        act_d    = fin_start;
      end else begin
        phase_d = i2cms_pkg::PH_READY;
        act_d   = fin_plain;
      end
    end

    // Transfer launch
    if (launch_w) begin
      phase_d = i2cms_pkg::PH_TX;
      err_d   = i2cms_pkg::RC_OK;
      pos_d   = '0;
      lim_d   = pw_cnt_d;
      awd_d   = {pw_addr_d, 1'b0};
    end
    if (launch_r) begin
      phase_d = i2cms_pkg::PH_RX;
      err_d   = i2cms_pkg::RC_OK;
      pos_d   = '0;
      lim_d   = (pr_cnt_d == '0) ? '0 : (pr_cnt_d - CNT_W'(1));
      awd_d   = {pr_addr_d, 1'b1};
    end

    if (i2cms_pkg::mode_e'(mode_q) == i2cms_pkg::MODE_EVENT) begin
      rc_d = err_d;
    end
  end

  assign stat_o.copy_start = launch_w && (pw_cnt_d != '0);
  assign stat_o.copy_last  = (CNT_W'(copy_idx_q) + CNT_W'(1)) == copy_n_q;

  // Item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q   <= mode_i;
      addr_q   <= target_address_i;
      count_q  <= byte_count_i;
      index_q  <= byte_index_i;
      data_q   <= data_byte_i;
      status_q <= bus_status_i;
    end
  end

  // Driver state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= i2cms_pkg::PH_READY;
      err_q     <= i2cms_pkg::RC_OK;
      pos_q     <= '0;
      lim_q     <= '0;
      awd_q     <= '0;
      pw_addr_q <= '0;
      pw_cnt_q  <= '0;
      pr_addr_q <= '0;
      pr_cnt_q  <= '0;
    end else if (cmd_i.exec) begin
      phase_q   <= phase_d;
      err_q     <= err_d;
      pos_q     <= pos_d;
      lim_q     <= lim_d;
      awd_q     <= awd_d;
      pw_addr_q <= pw_addr_d;
      pw_cnt_q  <= pw_cnt_d;
      pr_addr_q <= pr_addr_d;
      pr_cnt_q  <= pr_cnt_d;
    end
  end

  // Copy write strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cwr_q <= 1'b0;
    end else begin
      cwr_q <= cmd_i.copy_step;
    end
  end

  // Copy address walk and staging read
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      copy_idx_q <= '0;
      copy_n_q   <= pw_cnt_d;
    end else if (cmd_i.copy_step) begin
      copy_idx_q <= copy_idx_q + IDX_W'(1);
    end
    if (cmd_i.copy_step) begin
      stg_rd_q   <= stg_mem[copy_idx_q];
      cwr_addr_q <= copy_idx_q;
    end
  end

  // Staging store
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && stg_we) begin
      stg_mem[IDX_W'(index_q)] <= data_q;
    end
  end

  // Transfer store: copy port or received byte, one registered read
  always_ff @(posedge clk_i) begin
    if (cwr_q) begin
      xfer_mem[cwr_addr_q] <= stg_rd_q;
    end else if (cmd_i.exec && take_we) begin
      xfer_mem[IDX_W'(pos_q)] <= data_q;
    end
    if (cmd_i.fetch) begin
      xfer_rd_q <= xfer_mem[rd_addr];
    end
  end

  // Result hold and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_rc_q    <= rc_d;
      res_act_q   <= act_d;
      res_byte_q  <= byte_d;
      res_avail_q <= avail_d;
      res_bufb_q  <= bufb_d;
      res_phase_q <= phase_d;
    end
    if (cmd_i.load_out) begin
      rc_oq    <= res_rc_q;
      act_oq   <= res_act_q;
      byte_oq  <= res_byte_q;
      phase_oq <= res_phase_q;
      avail_oq <= res_avail_q;
      bufb_oq  <= res_bufb_q;
    end
  end

  assign return_code_o     = rc_oq;
  assign bus_action_o      = act_oq;
  assign bus_byte_o        = byte_oq;
  assign driver_state_o    = phase_oq;
  assign bytes_available_o = avail_oq;
  assign buffer_byte_o     = bufb_oq;

  `I2CMS_ASSERT(a_pos_bounded, clk_i, rst_ni, pos8 <= BUF_LIM)
  `I2CMS_ASSERT(a_xfer_one_writer, clk_i, rst_ni, !(cwr_q && cmd_i.exec && take_we))
  `I2CMS_ASSERT_NEXT(a_launch_clears_pos, clk_i, rst_ni, cmd_i.exec && (launch_w || launch_r), pos_q == '0)

endmodule

`default_nettype wire

### rtl/core/i2c_master_transfer_sequencer.sv
// I2C master transfer sequencer. Each input beat (stage a write byte,
// request a write or read, report a bus event, read the receive buffer)
// yields exactly one result beat with a return code, the bus action to
// take, the byte to send, the driver state and buffered read data. An
// ordinary beat passes through the fetch, execute and result states until the
// next beat can be taken; a beat that launches an N-byte write also passes
// through the copy and drain states, because the staged bytes move to the
// transfer buffer one per cycle through the staging buffer's single read port.
// The result sits in an output register, so a new beat is taken while it waits.
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer
// Top level: sequencing controller plus datapath with staging and
// transfer buffers.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_transfer_sequencer #(
  parameter int unsigned BUFFER_BYTES = i2cms_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [i2cms_pkg::MODE_W-1:0]     mode_i,
  input  wire logic [i2cms_pkg::ADDR_W-1:0]     target_address_i,
  input  wire logic [i2cms_pkg::COUNT_W-1:0]    byte_count_i,
  input  wire logic [i2cms_pkg::INDEX_W-1:0]    byte_index_i,
  input  wire logic [i2cms_pkg::BYTE_W-1:0]     data_byte_i,
  input  wire logic [i2cms_pkg::STATUS_W-1:0]   bus_status_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic      [i2cms_pkg::RC_W-1:0]       return_code_o,
  output logic      [i2cms_pkg::ACT_W-1:0]      bus_action_o,
  output logic      [i2cms_pkg::BYTE_W-1:0]     bus_byte_o,
  output logic      [i2cms_pkg::PHASE_W-1:0]    driver_state_o,
  output logic      [i2cms_pkg::AVAIL_W-1:0]    bytes_available_o,
  output logic      [i2cms_pkg::BYTE_W-1:0]     buffer_byte_o
);

  i2cms_pkg::cmd_t  cmd;
  i2cms_pkg::stat_t stat;

  // Sequencing controller
  i2cms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath
  i2cms_datapath #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .mode_i            (mode_i),
    .target_address_i  (target_address_i),
    .byte_count_i      (byte_count_i),
    .byte_index_i      (byte_index_i),
    .data_byte_i       (data_byte_i),
    .bus_status_i      (bus_status_i),
    .return_code_o     (return_code_o),
    .bus_action_o      (bus_action_o),
    .bus_byte_o        (bus_byte_o),
    .driver_state_o    (driver_state_o),
    .bytes_available_o (bytes_available_o),
    .buffer_byte_o     (buffer_byte_o)
  );

endmodule

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I2C master transfer sequencer. A scoreboard
// model predicts the reply to every accepted beat. Stimulus runs in three
// parts. A preload fills both byte stores. Directed beats hit the corner
// cases. Random write and read transactions follow, mixed with request
// races, buffer reads and noise. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int DEPTH = i2cms_pkg::BUFFER_BYTES_DEF;

  // Field widths
  localparam int unsigned MODE_W   = i2cms_pkg::MODE_W;
  localparam int unsigned ADDR_W   = i2cms_pkg::ADDR_W;
  localparam int unsigned COUNT_W  = i2cms_pkg::COUNT_W;
  localparam int unsigned INDEX_W  = i2cms_pkg::INDEX_W;
  localparam int unsigned BYTE_W   = i2cms_pkg::BYTE_W;
  localparam int unsigned STATUS_W = i2cms_pkg::STATUS_W;
  localparam int unsigned RC_W     = i2cms_pkg::RC_W;
  localparam int unsigned ACT_W    = i2cms_pkg::ACT_W;
  localparam int unsigned PHASE_W  = i2cms_pkg::PHASE_W;
  localparam int unsigned AVAIL_W  = i2cms_pkg::AVAIL_W;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [ADDR_W-1:0]   addr;
    logic [COUNT_W-1:0]  count;
    logic [INDEX_W-1:0]  index;
    logic [BYTE_W-1:0]   data;
    logic [STATUS_W-1:0] status;
    logic                hold;    // wait for all replies before offering this beat
  } beat_t;

  typedef struct packed {
    logic [RC_W-1:0]    rc;
    logic [ACT_W-1:0]   act;
    logic [BYTE_W-1:0]  bbyte;
    logic [PHASE_W-1:0] state;
    logic [AVAIL_W-1:0] avail;
    logic [BYTE_W-1:0]  bufb;
  } reply_t;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #10 clk_i = ~clk_i;

  // Handshake signals and the beat on the input port
  beat_t cur_beat   = '0;
  logic  beat_valid = 1'b0;
  logic  in_ready_o;
  logic  out_valid_o;
  logic  out_ready  = 1'b0;
  logic [RC_W-1:0]    return_code_o;
  logic [ACT_W-1:0]   bus_action_o;
  logic [BYTE_W-1:0]  bus_byte_o;
  logic [PHASE_W-1:0] driver_state_o;
  logic [AVAIL_W-1:0] bytes_available_o;
  logic [BYTE_W-1:0]  buffer_byte_o;

  i2c_master_transfer_sequencer u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (beat_valid),
    .in_ready_o        (in_ready_o),
    .mode_i            (cur_beat.mode),
    .target_address_i  (cur_beat.addr),
    .byte_count_i      (cur_beat.count),
    .byte_index_i      (cur_beat.index),
    .data_byte_i       (cur_beat.data),
    .bus_status_i      (cur_beat.status),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready),
    .return_code_o     (return_code_o),
    .bus_action_o      (bus_action_o),
    .bus_byte_o        (bus_byte_o),
    .driver_state_o    (driver_state_o),
    .bytes_available_o (bytes_available_o),
    .buffer_byte_o     (buffer_byte_o)
  );

  beat_t  sequencer_beats_q[$];
  reply_t expected_replies_q[$];

  int errors      = 0;
  int beats_in    = 0;
  int replies_out = 0;
  int launches    = 0;
  int deferred    = 0;
  int rejected    = 0;
  int dropped     = 0;

  // --------------------------------------------------------------------------
  // Scoreboard model of the sequencer
  // --------------------------------------------------------------------------
  i2cms_pkg::phase_e drv_phase  = i2cms_pkg::PH_READY;
  logic [RC_W-1:0]   drv_err    = i2cms_pkg::RC_OK;
  logic [5:0]      xfer_pos     = '0;
  logic [5:0]      xfer_limit   = '0;
  logic [7:0]      addr_dir     = '0;
  logic [6:0]      wr_pend_addr = '0;
  logic [5:0]      wr_pend_cnt  = '0;
  logic [6:0]      rd_pend_addr = '0;
  logic [5:0]      rd_pend_cnt  = '0;
  logic [7:0]      stage_mem[DEPTH];
  logic [7:0]      xfer_mem[DEPTH];

  function automatic void start_write();
    for (int i = 0; i < wr_pend_cnt && i < DEPTH; i++) xfer_mem[i] = stage_mem[i];
    drv_phase  = i2cms_pkg::PH_TX;
    drv_err    = i2cms_pkg::RC_OK;
    xfer_pos   = '0;
    xfer_limit = wr_pend_cnt;
    addr_dir   = {wr_pend_addr, 1'b0};
  endfunction

  function automatic void start_read();
    logic [5:0] n;
    n = (rd_pend_cnt != 0) ? rd_pend_cnt : 6'd1;   // zero-length read becomes one byte
    drv_phase  = i2cms_pkg::PH_RX;
    drv_err    = i2cms_pkg::RC_OK;
    xfer_pos   = '0;
    xfer_limit = n - 6'd1;
    addr_dir   = {rd_pend_addr, 1'b1};
  endfunction

  // Bus released: go ready, then launch whatever request was waiting
  function automatic i2cms_pkg::action_e end_of_ownership(i2cms_pkg::action_e plain,
                                                          i2cms_pkg::action_e with_start);
    i2cms_pkg::phase_e was;
    was       = drv_phase;
    drv_phase = i2cms_pkg::PH_READY;
    if (was == i2cms_pkg::PH_WPEND) begin
      start_write();
      return with_start;
    end
    if (was == i2cms_pkg::PH_RPEND) begin
      start_read();
      return with_start;
    end
    return plain;
  endfunction

  // Bytes past the end of the receive store are lost
  function automatic void capture_byte(logic [7:0] v);
    if (xfer_pos < DEPTH) begin
      xfer_mem[xfer_pos[4:0]] = v;
      xfer_pos++;
    end else begin
      dropped++;
    end
  endfunction

  function automatic i2cms_pkg::action_e bus_reaction(logic [3:0] st, logic [7:0] rx,
                                                      output logic [7:0] sent);
    i2cms_pkg::action_e act;
    sent = '0;
    act  = i2cms_pkg::ACT_NONE;
    case (st)
      i2cms_pkg::ST_START, i2cms_pkg::ST_REP_START: begin
        sent = addr_dir;
        act  = i2cms_pkg::ACT_SEND;
      end
      i2cms_pkg::ST_MT_SLA_ACK, i2cms_pkg::ST_MT_DAT_ACK: begin
        if (xfer_pos < xfer_limit && xfer_pos < DEPTH) begin
          sent = xfer_mem[xfer_pos[4:0]];
          xfer_pos++;
          act = i2cms_pkg::ACT_SEND;
        end else begin
          act = end_of_ownership(i2cms_pkg::ACT_STOP, i2cms_pkg::ACT_STOP_START);
        end
      end
      i2cms_pkg::ST_MT_SLA_NAK: begin
        drv_err = i2cms_pkg::RC_ADDR_NACK;
        act = end_of_ownership(i2cms_pkg::ACT_STOP, i2cms_pkg::ACT_STOP_START);
      end
      i2cms_pkg::ST_MT_DAT_NAK: begin
        drv_err = i2cms_pkg::RC_DATA_NACK;
        act = end_of_ownership(i2cms_pkg::ACT_STOP, i2cms_pkg::ACT_STOP_START);
      end
      i2cms_pkg::ST_ARB_LOST: begin
        drv_err = i2cms_pkg::RC_OTHER;
        act = end_of_ownership(i2cms_pkg::ACT_RELEASE, i2cms_pkg::ACT_RELEASE_START);
      end
      i2cms_pkg::ST_MR_DAT_ACK, i2cms_pkg::ST_MR_SLA_ACK: begin
        if (st == i2cms_pkg::ST_MR_DAT_ACK) capture_byte(rx);
        act = (xfer_pos < xfer_limit) ? i2cms_pkg::ACT_ACK : i2cms_pkg::ACT_NACK;
      end
      i2cms_pkg::ST_MR_DAT_NAK, i2cms_pkg::ST_MR_SLA_NAK: begin
        // address NACK on a read stops without an error code
        if (st == i2cms_pkg::ST_MR_DAT_NAK) capture_byte(rx);
        act = end_of_ownership(i2cms_pkg::ACT_STOP, i2cms_pkg::ACT_STOP_START);
      end
      i2cms_pkg::ST_BUS_ERROR: begin
        drv_err = i2cms_pkg::RC_OTHER;
        act = end_of_ownership(i2cms_pkg::ACT_STOP, i2cms_pkg::ACT_STOP_START);
      end
      default: act = i2cms_pkg::ACT_NONE;   // no info and unknown codes
    endcase
    return act;
  endfunction

  function automatic reply_t sequencer_step(beat_t b);
    reply_t     r;
    logic [7:0] sent;
    r = '0;
    case (b.mode)
      i2cms_pkg::MODE_STAGE: stage_mem[b.index] = b.data;
      i2cms_pkg::MODE_REQ_WR, i2cms_pkg::MODE_REQ_RD: begin
        if (b.count > DEPTH) begin
          r.rc = i2cms_pkg::RC_TOO_LONG;
        end else begin
          if (b.mode == i2cms_pkg::MODE_REQ_WR) begin
            wr_pend_addr = b.addr;
            wr_pend_cnt  = b.count[5:0];
          end else begin
            rd_pend_addr = b.addr;
            rd_pend_cnt  = b.count[5:0];
          end
          if (drv_phase == i2cms_pkg::PH_READY) begin
            if (b.mode == i2cms_pkg::MODE_REQ_WR) start_write();
            else start_read();
            r.act = i2cms_pkg::ACT_START;
            r.rc  = i2cms_pkg::RC_OK;
          end else begin
            // bus busy: request waits for the running transfer to end
            drv_phase = (b.mode == i2cms_pkg::MODE_REQ_WR) ? i2cms_pkg::PH_WPEND
                                                           : i2cms_pkg::PH_RPEND;
            r.rc      = drv_err;
          end
        end
      end
      i2cms_pkg::MODE_EVENT: begin
        r.act   = bus_reaction(b.status, b.data, sent);
        r.bbyte = sent;
        r.rc    = drv_err;
      end
      i2cms_pkg::MODE_READ_BUF: begin
        r.avail = (xfer_pos < b.count) ? xfer_pos : b.count[5:0];
        r.bufb  = xfer_mem[b.index];
      end
      default: ;
    endcase
    r.state = drv_phase;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: random gaps between beats, calm stretches with none
  // --------------------------------------------------------------------------
  int tx_gap  = 0;
  bit tx_calm = 1'b0;

  always @(posedge clk_i) begin : beat_driver
    beat_t  nxt;
    reply_t rep;
    logic   v;
    if (rst_ni) begin
      v = beat_valid;
      if (beat_valid && in_ready_o) begin
        rep = sequencer_step(cur_beat);
        expected_replies_q.push_back(rep);
        beats_in++;
        if (rep.act == i2cms_pkg::ACT_START) launches++;
        if (rep.act == i2cms_pkg::ACT_STOP_START ||
            rep.act == i2cms_pkg::ACT_RELEASE_START) deferred++;
        if (rep.rc == i2cms_pkg::RC_TOO_LONG) rejected++;
        v = 1'b0;
      end
      if (!v) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (sequencer_beats_q.size() > 0 &&
                     !(sequencer_beats_q[0].hold && expected_replies_q.size() > 0)) begin
          nxt = sequencer_beats_q.pop_front();
          cur_beat <= nxt;
          v = 1'b1;
          tx_gap = tx_calm ? 0 : $urandom_range(0, 4);
          if ($urandom_range(0, 63) == 0) tx_calm = !tx_calm;
        end
      end
      beat_valid <= v;
    end
  end

  // --------------------------------------------------------------------------
  // Reply monitor: random back-pressure, in-order compare
  // --------------------------------------------------------------------------
  int rx_hold = 0;
  bit rx_calm = 1'b0;

  task automatic note_fault(string msg);
    errors++;
    if (errors <= 10) $display("[%0t] MISMATCH %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want)
      note_fault($sformatf("reply %0d %s: expected %0d, got %0d", replies_out, name, want, got));
  endtask

  always @(posedge clk_i) begin : reply_monitor
    reply_t want;
    logic   rdy;
    if (rst_ni) begin
      rdy = out_ready;
      if (out_valid_o && out_ready) begin
        if (expected_replies_q.size() == 0) begin
          note_fault($sformatf("reply %0d arrived with nothing outstanding", replies_out));
        end else begin
          want = expected_replies_q.pop_front();
          check_field("return_code", want.rc, return_code_o);
          check_field("bus_action", want.act, bus_action_o);
          check_field("bus_byte", want.bbyte, bus_byte_o);
          check_field("driver_state", want.state, driver_state_o);
          check_field("bytes_available", want.avail, bytes_available_o);
          check_field("buffer_byte", want.bufb, buffer_byte_o);
        end
        replies_out++;
        rx_hold = rx_calm ? 0 : $urandom_range(0, 4);
        if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
        rdy = (rx_hold == 0);
      end else if (rx_hold > 0) begin
        rx_hold--;
        rdy = (rx_hold == 0);
      end else begin
        rdy = 1'b1;
      end
      out_ready <= rdy;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers; unused fields carry random values
  // --------------------------------------------------------------------------
  task automatic put_beat(int m, int a, int c, int i, int d, int s, bit h = 1'b0);
    beat_t b;
    b.mode   = MODE_W'(m);
    b.addr   = ADDR_W'(a);
    b.count  = COUNT_W'(c);
    b.index  = INDEX_W'(i);
    b.data   = BYTE_W'(d);
    b.status = STATUS_W'(s);
    b.hold   = h;
    sequencer_beats_q.push_back(b);
  endtask

  task automatic stage_byte(int idx, int val);
    put_beat(i2cms_pkg::MODE_STAGE, $urandom, $urandom, idx, val, $urandom);
  endtask

  task automatic request(int m, int adr, int cnt, bit h = 1'b0);
    put_beat(m, adr, cnt, $urandom, $urandom, $urandom, h);
  endtask

  task automatic bus_evt(int s);
    put_beat(i2cms_pkg::MODE_EVENT, $urandom, $urandom, $urandom, $urandom, s);
  endtask

  task automatic peek_rx(int idx, int cnt);
    put_beat(i2cms_pkg::MODE_READ_BUF, $urandom, cnt, idx, $urandom, $urandom);
  endtask

  // Mostly short transfers, now and then full size or oversize
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(DEPTH + 1, 255);
    if (r == 1) return DEPTH;
    return $urandom_range(0, 8);
  endfunction

  // Reset once
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Hard stop if the handshakes lock up
  initial begin
    #10ms;
    $display("DONE: errors detected");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int  directed_n;
    int  sel;
    int  len;
    int  k;
    int  m;
    int  extra;
    bit  hold;
    bit  quit;
    bit  first;

    // Preload: fill the staging store, then a full-size write copies it
    // into the transfer store so no entry is ever read unwritten
    for (int i = 0; i < DEPTH; i++)
      stage_byte(i, (i == 0) ? 8'h00 : (i == DEPTH - 1) ? 8'hFF : $urandom);
    request(i2cms_pkg::MODE_REQ_WR, 127, DEPTH);
    bus_evt(i2cms_pkg::ST_START);
    bus_evt(i2cms_pkg::ST_MT_SLA_ACK);

    // Request during a transfer, oversize requests, zero-length read launched
    // by the data NACK that ends the write
    request(i2cms_pkg::MODE_REQ_RD, 0, 0);
    request(i2cms_pkg::MODE_REQ_WR, 1, DEPTH + 1);
    request(i2cms_pkg::MODE_REQ_RD, 1, 255);
    bus_evt(i2cms_pkg::ST_MT_DAT_NAK);
    bus_evt(i2cms_pkg::ST_REP_START);
    bus_evt(i2cms_pkg::ST_MR_SLA_ACK);
    bus_evt(i2cms_pkg::ST_MR_DAT_NAK);
    peek_rx(0, 255);
    peek_rx(DEPTH - 1, 0);

    // Zero-length write, address NACK, arbitration loss with a pending write
    request(i2cms_pkg::MODE_REQ_WR, 85, 0);
    bus_evt(i2cms_pkg::ST_MT_SLA_ACK);
    request(i2cms_pkg::MODE_REQ_WR, 42, 1);
    bus_evt(i2cms_pkg::ST_MT_SLA_NAK);
    request(i2cms_pkg::MODE_REQ_RD, 5, 3);
    request(i2cms_pkg::MODE_REQ_WR, 9, 2, 1'b1);
    bus_evt(i2cms_pkg::ST_ARB_LOST);
    bus_evt(i2cms_pkg::ST_BUS_ERROR);
    bus_evt(i2cms_pkg::ST_NO_INFO);
    bus_evt(15);
    put_beat(5, $urandom, $urandom, $urandom, $urandom, $urandom);
    put_beat(7, $urandom, $urandom, $urandom, $urandom, $urandom);

    // Read address NACK, then a full read overrun past the store end
    request(i2cms_pkg::MODE_REQ_RD, 100, 4);
    bus_evt(i2cms_pkg::ST_MR_SLA_NAK);
    request(i2cms_pkg::MODE_REQ_RD, 6, DEPTH);
    bus_evt(i2cms_pkg::ST_START);
    bus_evt(i2cms_pkg::ST_MR_SLA_ACK);
    repeat (DEPTH + 2) bus_evt(i2cms_pkg::ST_MR_DAT_ACK);
    bus_evt(i2cms_pkg::ST_MR_DAT_NAK);
    peek_rx(DEPTH - 1, DEPTH);
    directed_n = sequencer_beats_q.size();

    // Random transactions
    first = 1'b1;
    while (sequencer_beats_q.size() < directed_n + 900) begin
      sel   = $urandom_range(0, 99);
      hold  = first || ($urandom_range(0, 29) == 0);
      first = 1'b0;
      len   = pick_len();
      if (sel < 30) begin
        // write: stage, request, address phase, data phase, close
        repeat ($urandom_range(0, 4)) stage_byte($urandom_range(0, DEPTH - 1), $urandom);
        request(i2cms_pkg::MODE_REQ_WR, $urandom_range(0, 127), len, hold);
        bus_evt($urandom_range(0, 1) ? i2cms_pkg::ST_REP_START : i2cms_pkg::ST_START);
        if ($urandom_range(0, 9) == 0) begin
          bus_evt(i2cms_pkg::ST_MT_SLA_NAK);
        end else begin
          bus_evt(i2cms_pkg::ST_MT_SLA_ACK);
          quit = 1'b0;
          for (k = 0; k < ((len > DEPTH) ? 2 : len) && !quit; k++) begin
            m = $urandom_range(0, 39);
            if (m == 0) begin
              bus_evt(i2cms_pkg::ST_MT_DAT_NAK);
              quit = 1'b1;
            end else begin
              if (m == 1) request(i2cms_pkg::MODE_REQ_RD, $urandom_range(0, 127), pick_len());
              bus_evt(i2cms_pkg::ST_MT_DAT_ACK);
            end
          end
          if (!quit)
            bus_evt(($urandom_range(0, 19) == 0) ? i2cms_pkg::ST_ARB_LOST
                                                 : i2cms_pkg::ST_MT_DAT_ACK);
        end
      end else if (sel < 55) begin
        // read: request, address phase, data bytes, final NACK, read-out
        request(i2cms_pkg::MODE_REQ_RD, $urandom_range(0, 127), len, hold);
        bus_evt($urandom_range(0, 1) ? i2cms_pkg::ST_REP_START : i2cms_pkg::ST_START);
        if ($urandom_range(0, 9) == 0) begin
          bus_evt(i2cms_pkg::ST_MR_SLA_NAK);
        end else begin
          bus_evt(i2cms_pkg::ST_MR_SLA_ACK);
          m     = (len == 0 || len > DEPTH) ? 1 : len;
          extra = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
          if ($urandom_range(0, 19) == 0) request(i2cms_pkg::MODE_REQ_WR, $urandom, pick_len());
          repeat (m - 1 + extra) bus_evt(i2cms_pkg::ST_MR_DAT_ACK);
          bus_evt(($urandom_range(0, 19) == 0) ? i2cms_pkg::ST_BUS_ERROR
                                               : i2cms_pkg::ST_MR_DAT_NAK);
          repeat ($urandom_range(1, 3))
            peek_rx($urandom_range(0, DEPTH - 1), $urandom_range(0, DEPTH + 8));
        end
      end else if (sel < 70) begin
        peek_rx($urandom_range(0, DEPTH - 1), $urandom_range(0, 255));
      end else if (sel < 80) begin
        request($urandom_range(i2cms_pkg::MODE_REQ_WR, i2cms_pkg::MODE_REQ_RD),
                $urandom_range(0, 127), pick_len(), hold);
      end else begin
        // noise: any mode, any status, any field
        put_beat($urandom_range(0, 7), $urandom, $urandom, $urandom, $urandom,
                 $urandom_range(0, 15), hold);
      end
    end

    // Drain
    while (sequencer_beats_q.size() != 0 || beat_valid || expected_replies_q.size() != 0)
      @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (expected_replies_q.size() != 0)
      note_fault($sformatf("%0d replies never arrived", expected_replies_q.size()));

    $display("Checked %0d replies to %0d beats: %0d direct launches, %0d launches on release",
             replies_out, beats_in, launches, deferred);
    $display("Oversize requests rejected: %0d, received bytes lost past the buffer end: %0d",
             rejected, dropped);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
